[src/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers shared by the RTL. Each macro expects clk and rst to be
// in scope and disables the check while rst is high.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define CF_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define CF_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/cf_pkg.sv]
// ----------------------------------------------------------------------------
// cf_pkg
// Shared types, constants and the hash step of the cuckoo filter engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package cf_pkg;

  localparam int unsigned BUCKETS_DEFAULT  = 128;
  localparam int unsigned KEY_W            = 16;
  localparam int unsigned FP_W             = 16;
  localparam int unsigned CNT_W            = 8;
  localparam int unsigned CMD_W            = 2;

  localparam logic [FP_W-1:0]  HASH_SEED       = 16'd5381;
  localparam logic [CNT_W-1:0] MAX_RELOC_RESET = 8'd8;

  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;

  typedef logic [FP_W-1:0] fp_t;

  // Result of the shared hash unit.
  typedef struct packed {
    logic done;
    fp_t  hash;
  } cf_hash_rsp_t;

  // One DJB round: h * 33 + byte, kept to 16 bits.
  function automatic fp_t djb_step(input fp_t h, input logic [7:0] b);
    djb_step = {h[FP_W-6:0], 5'b0} + h + {8'b0, b};
  endfunction

endpackage

`default_nettype wire

[src/cf_if.sv]
// ----------------------------------------------------------------------------
// cf_req_if / cf_rsp_if
// Valid/ready channels carrying commands into and results out of the engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface cf_req_if import cf_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CMD_W-1:0] command;
  logic [KEY_W-1:0] key;
  logic             evict_second;

  modport source (output valid, command, key, evict_second, input ready);
  modport sink   (input valid, command, key, evict_second, output ready);
endinterface

interface cf_rsp_if import cf_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             inserted;
  logic             found;
  logic [CNT_W-1:0] relocations_used;

  modport source (output valid, inserted, found, relocations_used, input ready);
  modport sink   (input valid, inserted, found, relocations_used, output ready);
endinterface

`default_nettype wire

[src/cf_hash_unit.sv]
// ----------------------------------------------------------------------------
// cf_hash_unit
// Iterative 16-bit DJB hash over two bytes, low byte first, one byte a cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cf_hash_unit import cf_pkg::*; (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         start,
  input  wire fp_t          value,
  output cf_hash_rsp_t      rsp
);

  logic       busy;
  logic       done;
  logic [7:0] hi_byte;
  fp_t        h;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= busy;
      if (start) begin
        busy <= 1'b1;
      end else begin
        busy <= 1'b0;
      end
    end
    if (start) begin
      h       <= djb_step(HASH_SEED, value[7:0]);
      hi_byte <= value[15:8];
    end else if (busy) begin
      h <= djb_step(h, hi_byte);
    end
  end

  assign rsp.done = done;
  assign rsp.hash = h;

endmodule

`default_nettype wire

[src/cuckoo_filter_engine.sv]
// ----------------------------------------------------------------------------
// cuckoo_filter_engine
// Cuckoo filter over a table of single-fingerprint buckets.
// ----------------------------------------------------------------------------
// Commands arrive on req (valid/ready) and each accepted transaction yields
// exactly one result transaction on rsp. Command 0 inserts the key, 1 looks
// it up, 2 empties the table; command 3 does nothing and returns zeros.
// One command is in flight at a time: req.ready is high only while idle, and
// a result waits in its output register until rsp.ready, so a stall on rsp
// holds off the next command and nothing is lost.
// Sequence: the key and fingerprint hashes share one hash unit, then two
// table reads and a decision cycle follow; a lookup or a direct insert ends
// there. Each relocation hashes the victim, reads its alternate bucket and
// decides, and an insert makes at most limit + 1 such rounds. Clear sweeps
// the table one bucket a cycle; command 3 goes straight to its result. The
// next command is taken only after the result has been taken. After reset
// the same sweep holds req.ready low until every bucket is cleared.
// cfg_write loads the relocation limit (reset 8); the user must load it only
// while idle, as the block itself does not enforce this.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module cuckoo_filter_engine import cf_pkg::*; #(
  parameter int unsigned BUCKETS = BUCKETS_DEFAULT
) (
  input  wire logic       clk,
  input  wire logic       rst,
  cf_req_if.sink          req,
  cf_rsp_if.source        rsp,
  input  wire logic       cfg_write,
  input  wire logic [7:0] cfg_data
);

  localparam int unsigned IDX_W = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam logic [IDX_W-1:0] IDX_MASK  = IDX_W'(BUCKETS - 1);
  localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(BUCKETS - 1);

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_HKEY,
    S_HFP,
    S_RD1,
    S_RD2,
    S_CHK,
    S_HALT,
    S_RDN,
    S_MOVE,
    S_RESP
  } state_t;

  // Bucket table: one write port, one registered read port.
  fp_t table_mem [BUCKETS];
  fp_t rdata;

  state_t           state;
  logic [CMD_W-1:0] cmd_q;
  logic             evict_q;
  fp_t              fp;
  fp_t              b1;
  fp_t              vfp;
  logic [IDX_W-1:0] i1;
  logic [IDX_W-1:0] i2;
  logic [IDX_W-1:0] vidx;
  logic [IDX_W-1:0] nidx;
  logic [IDX_W-1:0] clr_addr;
  logic             clr_reply;
  logic [CNT_W-1:0] moves;
  logic [CNT_W-1:0] reloc_max;
  logic             ins_q;
  logic             fnd_q;

  logic             accept;
  logic             hash_start;
  fp_t              hash_value;
  cf_hash_rsp_t     hash_rsp;
  logic [IDX_W-1:0] hash_idx;
  logic [IDX_W-1:0] rd_addr;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  fp_t              wr_data;

  assign accept     = req.valid && req.ready;
  assign req.ready  = (state == S_IDLE);
  assign rsp.valid  = (state == S_RESP);
  assign rsp.inserted         = ins_q;
  assign rsp.found            = fnd_q;
  assign rsp.relocations_used = moves;

  assign hash_idx = hash_rsp.hash[IDX_W-1:0] & IDX_MASK;

  cf_hash_unit u_hash (
    .clk   (clk),
    .rst   (rst),
    .start (hash_start),
    .value (hash_value),
    .rsp   (hash_rsp)
  );

  // The one hash unit serves the key, the fingerprint and every victim.
  always_comb begin
    hash_start = 1'b0;
    hash_value = req.key;
    case (state)
      S_IDLE: begin
        hash_start = accept && (req.command == CMD_INSERT || req.command == CMD_LOOKUP);
        hash_value = req.key;
      end
      S_HKEY: begin
        hash_start = hash_rsp.done;
        hash_value = hash_rsp.hash;
      end
      S_CHK: begin
        hash_start = (cmd_q == CMD_INSERT) && (b1 != '0) && (rdata != '0);
        hash_value = evict_q ? b1 : rdata;
      end
      S_MOVE: begin
        hash_start = (rdata != '0) && (moves < reloc_max);
        hash_value = rdata;
      end
      default: begin
        hash_start = 1'b0;
      end
    endcase
  end

  always_comb begin
    case (state)
      S_RD1:   rd_addr = i1;
      S_RD2:   rd_addr = i2;
      default: rd_addr = nidx;
    endcase
  end

  // Table writes: the clearing sweep, a direct placement, the eviction of a
  // full candidate bucket, and each relocation move.
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = nidx;
    wr_data = vfp;
    case (state)
      S_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_addr;
        wr_data = '0;
      end
      S_CHK: begin
        wr_data = fp;
        if (cmd_q == CMD_INSERT) begin
          wr_en = 1'b1;
          if (b1 == '0) begin
            wr_addr = i1;
          end else if (rdata == '0) begin
            wr_addr = i2;
          end else begin
            wr_addr = evict_q ? i1 : i2;
          end
        end
      end
      S_MOVE: begin
        wr_en   = (rdata == '0) || (moves < reloc_max);
        wr_addr = nidx;
        wr_data = vfp;
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      table_mem[wr_addr] <= wr_data;
    end
    rdata <= table_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      reloc_max <= MAX_RELOC_RESET;
    end else if (cfg_write) begin
      reloc_max <= cfg_data;
    end
  end

  // Sequencer and registered results.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_addr  <= '0;
      clr_reply <= 1'b0;
      ins_q     <= 1'b0;
      fnd_q     <= 1'b0;
      moves     <= '0;
    end else begin
      case (state)
        S_CLEAR: begin
          if (clr_addr == LAST_IDX) begin
            clr_addr <= '0;
            state    <= clr_reply ? S_RESP : S_IDLE;
          end else begin
            clr_addr <= clr_addr + IDX_W'(1);
          end
        end
        S_IDLE: begin
          if (accept) begin
            cmd_q     <= req.command;
            evict_q   <= req.evict_second;
            ins_q     <= 1'b0;
            fnd_q     <= 1'b0;
            moves     <= '0;
            clr_reply <= 1'b1;
            case (req.command)
              CMD_INSERT: state <= S_HKEY;
              CMD_LOOKUP: state <= S_HKEY;
              CMD_CLEAR:  state <= S_CLEAR;
              default:    state <= S_RESP;
            endcase
          end
        end
        S_HKEY: begin
          if (hash_rsp.done) begin
            fp    <= hash_rsp.hash;
            i1    <= hash_rsp.hash[IDX_W-1:0] & IDX_MASK;
            state <= S_HFP;
          end
        end
        S_HFP: begin
          if (hash_rsp.done) begin
            i2    <= (i1 ^ hash_idx) & IDX_MASK;
            state <= S_RD1;
          end
        end
        S_RD1: begin
          state <= S_RD2;
        end
        S_RD2: begin
          b1    <= rdata;
          state <= S_CHK;
        end
        S_CHK: begin
          // rdata now holds the second candidate bucket.
          if (cmd_q == CMD_LOOKUP) begin
            fnd_q <= (b1 == fp) || (rdata == fp);
            state <= S_RESP;
          end else if (b1 == '0 || rdata == '0) begin
            ins_q <= 1'b1;
            state <= S_RESP;
          end else begin
            vidx  <= evict_q ? i1 : i2;
            vfp   <= evict_q ? b1 : rdata;
            state <= S_HALT;
          end
        end
        S_HALT: begin
          if (hash_rsp.done) begin
            nidx  <= (vidx ^ hash_idx) & IDX_MASK;
            state <= S_RDN;
          end
        end
        S_RDN: begin
          state <= S_MOVE;
        end
        S_MOVE: begin
          if (rdata == '0) begin
            ins_q <= 1'b1;
            state <= S_RESP;
          end else if (moves >= reloc_max) begin
            // The fingerprint in hand is dropped.
            state <= S_RESP;
          end else begin
            moves <= moves + CNT_W'(1);
            vidx  <= nidx;
            vfp   <= rdata;
            state <= S_HALT;
          end
        end
        S_RESP: begin
          if (rsp.ready) begin
            clr_reply <= 1'b0;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // A command in progress never overlaps a waiting result.
  `CF_ASSERT_IMP(a_ready_excl, req.ready, !rsp.valid, "ready while result pending")
  // After acceptance req.ready is low in the next cycle.
  `CF_ASSERT_NXT(a_busy_after_acc, accept, !req.ready, "ready right after accept")
  // Only lookups report found, and lookups never insert or relocate.
  `CF_ASSERT_IMP(a_found_lookup, rsp.valid && rsp.found,
                 !rsp.inserted && rsp.relocations_used == '0, "found with insert fields")

endmodule

`default_nettype wire
